FILE: rtl/core/ecmb_pkg.sv
// Shared types, codes and helpers for the mailbox transfer core.
// Used by ecmb_regs, ecmb_ctrl, ecmb_dp and ec_mailbox_transfer_core.
package ecmb_pkg;

	localparam int MAILBOX_BYTES = 16;
	localparam int CUR_W         = $clog2(MAILBOX_BYTES);

	// Input item kinds
	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_START  = 2'd1;
	localparam logic [1:0] KIND_ANSWER = 2'd2;
	localparam logic [1:0] KIND_READ   = 2'd3;

	// Result op codes
	localparam logic [2:0] OP_BUS_READ  = 3'd0;
	localparam logic [2:0] OP_BUS_WRITE = 3'd1;
	localparam logic [2:0] OP_WAIT      = 3'd2;
	localparam logic [2:0] OP_DONE      = 3'd3;
	localparam logic [2:0] OP_BUF_BYTE  = 3'd4;

	// Transfer outcomes
	localparam logic [1:0] OUTC_OK         = 2'd0;
	localparam logic [1:0] OUTC_NO_GRANT   = 2'd1;
	localparam logic [1:0] OUTC_NO_REPLY   = 2'd2;

	// Bus port offsets
	localparam logic [4:0] ST_PORT   = 5'h04;
	localparam logic [4:0] BASE_PORT = 5'h10;
	localparam logic [4:0] RET_PORT  = 5'h1f;

	// Status bit positions
	localparam int OBF_POS  = 6;
	localparam int MWMF_POS = 5;
	localparam int SWMF_POS = 4;

	// Mask bit always forced on at start (return byte)
	localparam logic [15:0] RET_BIT = 16'h8000;
	localparam logic [7:0]  RET_INIT = 8'h01;

	// Configuration register indexes and reset values
	localparam logic [1:0] REG_ATTEMPT_LIMIT = 2'd0;
	localparam logic [1:0] REG_GRANT_WAIT    = 2'd1;
	localparam logic [1:0] REG_REPLY_WAIT    = 2'd2;
	localparam logic [7:0] ATTEMPT_LIMIT_RST = 8'd100;
	localparam logic [9:0] GRANT_WAIT_RST    = 10'd1;
	localparam logic [9:0] REPLY_WAIT_RST    = 10'd500;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ARB_STATUS,
		PH_ARB_DRAIN,
		PH_ARB_CHECK,
		PH_REPLY,
		PH_READING
	} phase_t;

	typedef enum logic [3:0] {
		SQ_IDLE,
		SQ_BYTE,
		SQ_STATUS,
		SQ_RET,
		SQ_CMD,
		SQ_GWAIT_MORE,
		SQ_GWAIT_FAIL,
		SQ_RWAIT_MORE,
		SQ_RWAIT_FAIL,
		SQ_DONE_OK,
		SQ_DONE_GRANT,
		SQ_DONE_REPLY,
		SQ_RDBYTE,
		SQ_WR_FETCH,
		SQ_WR_OUT
	} seq_state_t;

	typedef enum logic [3:0] {
		EMIT_NONE,
		EMIT_STATUS,
		EMIT_RET,
		EMIT_CMD,
		EMIT_WRBYTE,
		EMIT_RDBYTE,
		EMIT_GWAIT,
		EMIT_RWAIT,
		EMIT_DONE,
		EMIT_BYTE
	} emit_t;

	typedef enum logic [2:0] {
		CUR_HOLD,
		CUR_FIRST_WR,
		CUR_NEXT_WR,
		CUR_FIRST_RD,
		CUR_NEXT_RD
	} cur_op_t;

	typedef enum logic [1:0] {
		WSEL_LOAD,
		WSEL_RET,
		WSEL_CURSOR
	} wsel_t;

	typedef enum logic [1:0] {
		RSEL_INDEX,
		RSEL_ZERO,
		RSEL_CURSOR
	} rsel_t;

	typedef struct packed {
		logic    start;
		logic    cnt_clr;
		logic    cnt_inc;
		cur_op_t cur_op;
		logic    mem_we;
		wsel_t   wsel;
		logic    rd_en;
		rsel_t   rsel;
		emit_t   emit;
		logic [1:0] outcome;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic cnt_hit;
		logic wr_more;
		logic rd_more;
	} stat_t;

	// Lowest set mask bit at or above position from; MSB of result flags a hit
	function automatic logic [CUR_W:0] next_set(input logic [MAILBOX_BYTES-1:0] mask,
			input logic [CUR_W:0] from);
		logic [CUR_W:0] res;
		res = '0;
		for (int i = MAILBOX_BYTES - 1; i >= 0; i--) begin
			if (mask[i] && ((CUR_W+1)'(i) >= from)) begin
				res = {1'b1, CUR_W'(i)};
			end
		end
		return res;
	endfunction

endpackage

FILE: rtl/core/ecmb_regs.sv
// APB-style configuration registers of the mailbox transfer core.
// Depends on ecmb_pkg for register indexes and reset values.
module ecmb_regs
	import ecmb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [7:0]  attempt_limit,
	output logic [9:0]  grant_wait_us,
	output logic [9:0]  reply_wait_us
);

	logic [7:0] attempt_limit_q;
	logic [9:0] grant_wait_q;
	logic [9:0] reply_wait_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	// Update a register on the access phase of a write transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attempt_limit_q <= ATTEMPT_LIMIT_RST;
			grant_wait_q    <= GRANT_WAIT_RST;
			reply_wait_q    <= REPLY_WAIT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ATTEMPT_LIMIT: attempt_limit_q <= pwdata[7:0];
				REG_GRANT_WAIT:    grant_wait_q    <= pwdata[9:0];
				REG_REPLY_WAIT:    reply_wait_q    <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	// Return the addressed register
	always_comb begin
		case (reg_idx)
			REG_ATTEMPT_LIMIT: prdata = {24'd0, attempt_limit_q};
			REG_GRANT_WAIT:    prdata = {22'd0, grant_wait_q};
			REG_REPLY_WAIT:    prdata = {22'd0, reply_wait_q};
			default:           prdata = '0;
		endcase
	end

	assign attempt_limit = attempt_limit_q;
	assign grant_wait_us = grant_wait_q;
	assign reply_wait_us = reply_wait_q;

endmodule

FILE: rtl/core/ecmb_ctrl.sv
// Controller of the mailbox transfer core: transfer phase and result sequencer.
// Depends on ecmb_pkg; drives ecmb_dp through cmd_t and reads stat_t.
module ecmb_ctrl
	import ecmb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] kind,
	input  logic [7:0] value,
	input  stat_t      stat,
	output logic       in_stall,
	output cmd_t       cmd
);

	seq_state_t state_q, state_nxt;
	phase_t     phase_q, phase_nxt;
	logic       accept;

	assign accept   = in_valid && (state_q == SQ_IDLE);
	assign in_stall = (state_q != SQ_IDLE);

	// Next sequencer state and transfer phase
	always_comb begin
		state_nxt = state_q;
		phase_nxt = phase_q;
		case (state_q)
			SQ_IDLE: begin
				if (accept) begin
					case (kind)
						KIND_READ: state_nxt = SQ_BYTE;
						KIND_START: begin
							if (phase_q == PH_IDLE) begin
								state_nxt = SQ_STATUS;
								phase_nxt = PH_ARB_STATUS;
							end
						end
						KIND_ANSWER: begin
							case (phase_q)
								PH_ARB_STATUS: begin
									if (value[OBF_POS] || value[SWMF_POS]) begin
										state_nxt = SQ_RET;
										phase_nxt = PH_ARB_DRAIN;
									end else begin
										state_nxt = SQ_CMD;
										phase_nxt = PH_ARB_CHECK;
									end
								end
								PH_ARB_DRAIN: begin
									if (stat.cnt_hit) begin
										state_nxt = SQ_DONE_GRANT;
										phase_nxt = PH_IDLE;
									end else begin
										state_nxt = SQ_STATUS;
										phase_nxt = PH_ARB_STATUS;
									end
								end
								PH_ARB_CHECK: begin
									if (value[MWMF_POS]) begin
										state_nxt = SQ_WR_FETCH;
										phase_nxt = PH_REPLY;
									end else if (stat.cnt_hit) begin
										state_nxt = SQ_GWAIT_FAIL;
										phase_nxt = PH_IDLE;
									end else begin
										state_nxt = SQ_GWAIT_MORE;
										phase_nxt = PH_ARB_STATUS;
									end
								end
								PH_REPLY: begin
									if (value[OBF_POS]) begin
										state_nxt = SQ_RDBYTE;
										phase_nxt = PH_READING;
									end else if (stat.cnt_hit) begin
										state_nxt = SQ_RWAIT_FAIL;
										phase_nxt = PH_IDLE;
									end else begin
										state_nxt = SQ_RWAIT_MORE;
									end
								end
								PH_READING: begin
									if (stat.rd_more) begin
										state_nxt = SQ_RDBYTE;
									end else begin
										state_nxt = SQ_DONE_OK;
										phase_nxt = PH_IDLE;
									end
								end
								default: ;
							endcase
						end
						default: ;
					endcase
				end
			end
			SQ_BYTE, SQ_STATUS, SQ_RET, SQ_RDBYTE,
			SQ_DONE_OK, SQ_DONE_GRANT, SQ_DONE_REPLY: begin
				if (stat.out_free) state_nxt = SQ_IDLE;
			end
			SQ_CMD, SQ_GWAIT_MORE, SQ_RWAIT_MORE: begin
				if (stat.out_free) state_nxt = SQ_STATUS;
			end
			SQ_GWAIT_FAIL: begin
				if (stat.out_free) state_nxt = SQ_DONE_GRANT;
			end
			SQ_RWAIT_FAIL: begin
				if (stat.out_free) state_nxt = SQ_DONE_REPLY;
			end
			SQ_WR_FETCH: state_nxt = SQ_WR_OUT;
			SQ_WR_OUT: begin
				if (stat.out_free) begin
					state_nxt = stat.wr_more ? SQ_WR_FETCH : SQ_STATUS;
				end
			end
			default: state_nxt = SQ_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd = '0;
		cmd.cur_op = CUR_HOLD;
		cmd.wsel   = WSEL_LOAD;
		cmd.rsel   = RSEL_INDEX;
		cmd.emit   = EMIT_NONE;
		case (state_q)
			SQ_IDLE: begin
				if (accept) begin
					case (kind)
						KIND_LOAD: begin
							cmd.mem_we = 1'b1;
							cmd.wsel   = WSEL_LOAD;
						end
						KIND_READ: begin
							cmd.rd_en = 1'b1;
							cmd.rsel  = RSEL_INDEX;
						end
						KIND_START: begin
							if (phase_q == PH_IDLE) begin
								cmd.start   = 1'b1;
								cmd.cnt_clr = 1'b1;
								cmd.mem_we  = 1'b1;
								cmd.wsel    = WSEL_RET;
							end
						end
						KIND_ANSWER: begin
							case (phase_q)
								PH_ARB_STATUS: begin
									cmd.rd_en = 1'b1;
									cmd.rsel  = RSEL_ZERO;
								end
								PH_ARB_DRAIN: cmd.cnt_inc = 1'b1;
								PH_ARB_CHECK: begin
									if (value[MWMF_POS]) begin
										cmd.cnt_clr = 1'b1;
										cmd.cur_op  = CUR_FIRST_WR;
									end else begin
										cmd.cnt_inc = 1'b1;
									end
								end
								PH_REPLY: begin
									if (value[OBF_POS]) begin
										cmd.cur_op = CUR_FIRST_RD;
									end else begin
										cmd.cnt_inc = 1'b1;
									end
								end
								PH_READING: begin
									cmd.mem_we = 1'b1;
									cmd.wsel   = WSEL_CURSOR;
									if (stat.rd_more) cmd.cur_op = CUR_NEXT_RD;
								end
								default: ;
							endcase
						end
						default: ;
					endcase
				end
			end
			SQ_BYTE:       if (stat.out_free) cmd.emit = EMIT_BYTE;
			SQ_STATUS:     if (stat.out_free) cmd.emit = EMIT_STATUS;
			SQ_RET:        if (stat.out_free) cmd.emit = EMIT_RET;
			SQ_CMD:        if (stat.out_free) cmd.emit = EMIT_CMD;
			SQ_RDBYTE:     if (stat.out_free) cmd.emit = EMIT_RDBYTE;
			SQ_GWAIT_MORE,
			SQ_GWAIT_FAIL: if (stat.out_free) cmd.emit = EMIT_GWAIT;
			SQ_RWAIT_MORE,
			SQ_RWAIT_FAIL: if (stat.out_free) cmd.emit = EMIT_RWAIT;
			SQ_DONE_OK: begin
				if (stat.out_free) cmd.emit = EMIT_DONE;
				cmd.outcome = OUTC_OK;
			end
			SQ_DONE_GRANT: begin
				if (stat.out_free) cmd.emit = EMIT_DONE;
				cmd.outcome = OUTC_NO_GRANT;
			end
			SQ_DONE_REPLY: begin
				if (stat.out_free) cmd.emit = EMIT_DONE;
				cmd.outcome = OUTC_NO_REPLY;
			end
			SQ_WR_FETCH: begin
				cmd.rd_en = 1'b1;
				cmd.rsel  = RSEL_CURSOR;
			end
			SQ_WR_OUT: begin
				if (stat.out_free) begin
					cmd.emit = EMIT_WRBYTE;
					if (stat.wr_more) cmd.cur_op = CUR_NEXT_WR;
				end
			end
			default: ;
		endcase
	end

	// Hold sequencer state and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			phase_q <= PH_IDLE;
		end else begin
			state_q <= state_nxt;
			phase_q <= phase_nxt;
		end
	end

endmodule

FILE: rtl/core/ecmb_dp.sv
// Datapath of the mailbox transfer core: buffer memory, masks, counters, result register.
// Depends on ecmb_pkg; commanded by ecmb_ctrl through cmd_t.
module ecmb_dp
	import ecmb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic [3:0]  index,
	input  logic [7:0]  value,
	input  logic [15:0] write_mask,
	input  logic [15:0] read_mask,
	input  logic [7:0]  attempt_limit,
	input  logic [9:0]  grant_wait_us,
	input  logic [9:0]  reply_wait_us,
	input  logic        out_stall,
	output logic        out_valid,
	output logic [2:0]  op,
	output logic [4:0]  bus_address,
	output logic [7:0]  write_data,
	output logic [9:0]  wait_us,
	output logic [1:0]  outcome,
	output logic [7:0]  buffer_byte,
	output logic        last
);

	logic [7:0]               buf_mem [MAILBOX_BYTES];
	logic [7:0]               rd_q;
	logic [CUR_W-1:0]         waddr, raddr;
	logic [7:0]               wdata;
	logic [MAILBOX_BYTES-1:0] wmask_q, rmask_q;
	logic [CUR_W-1:0]         cursor_q;
	logic [7:0]               cnt_q;
	logic [7:0]               cnt_inc;
	logic [CUR_W:0]           after_cur;
	logic [CUR_W:0]           first_wr, next_wr, first_rd, next_rd;
	logic [4:0]               cur_port;

	logic       out_valid_q;
	logic [2:0] op_q;
	logic [4:0] addr_q;
	logic [7:0] data_q;
	logic [9:0] wait_q;
	logic [1:0] outc_q;
	logic [7:0] byte_q;
	logic       last_q;

	// Mask searches from the start of the masks and from the cursor
	assign after_cur = {1'b0, cursor_q} + (CUR_W+1)'(1);
	assign first_wr  = next_set(wmask_q, (CUR_W+1)'(1));
	assign next_wr   = next_set(wmask_q, after_cur);
	assign first_rd  = next_set(rmask_q, '0);
	assign next_rd   = next_set(rmask_q, after_cur);
	assign cnt_inc   = cnt_q + 8'd1;
	assign cur_port  = BASE_PORT | {1'b0, cursor_q};

	assign stat.out_free = !out_valid_q || !out_stall;
	assign stat.cnt_hit  = (cnt_inc == attempt_limit);
	assign stat.wr_more  = next_wr[CUR_W];
	assign stat.rd_more  = next_rd[CUR_W];

	// Select buffer write and read ports
	always_comb begin
		case (cmd.wsel)
			WSEL_RET: begin
				waddr = CUR_W'(MAILBOX_BYTES - 1);
				wdata = RET_INIT;
			end
			WSEL_CURSOR: begin
				waddr = cursor_q;
				wdata = value;
			end
			default: begin
				waddr = index;
				wdata = value;
			end
		endcase
		case (cmd.rsel)
			RSEL_ZERO:   raddr = '0;
			RSEL_CURSOR: raddr = cursor_q;
			default:     raddr = index;
		endcase
	end

	// Buffer memory with registered read
	always_ff @(posedge clk) begin
		if (cmd.mem_we) buf_mem[waddr] <= wdata;
		if (cmd.rd_en) rd_q <= buf_mem[raddr];
	end

	// Transfer masks, attempt counter and byte cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wmask_q  <= '0;
			rmask_q  <= '0;
			cnt_q    <= '0;
			cursor_q <= '0;
		end else begin
			if (cmd.start) begin
				wmask_q  <= write_mask | RET_BIT;
				rmask_q  <= read_mask | RET_BIT;
				cursor_q <= '0;
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_inc;
			end
			case (cmd.cur_op)
				CUR_FIRST_WR: cursor_q <= first_wr[CUR_W-1:0];
				CUR_NEXT_WR:  cursor_q <= next_wr[CUR_W-1:0];
				CUR_FIRST_RD: cursor_q <= first_rd[CUR_W-1:0];
				CUR_NEXT_RD:  cursor_q <= next_rd[CUR_W-1:0];
				default: ;
			endcase
		end
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit != EMIT_NONE) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Build the result payload
	always_ff @(posedge clk) begin
		if (cmd.emit != EMIT_NONE) begin
			op_q   <= OP_BUS_READ;
			addr_q <= '0;
			data_q <= '0;
			wait_q <= '0;
			outc_q <= '0;
			byte_q <= '0;
			last_q <= 1'b1;
			case (cmd.emit)
				EMIT_STATUS: addr_q <= ST_PORT;
				EMIT_RET:    addr_q <= RET_PORT;
				EMIT_RDBYTE: addr_q <= cur_port;
				EMIT_CMD: begin
					op_q   <= OP_BUS_WRITE;
					addr_q <= BASE_PORT;
					data_q <= rd_q;
					last_q <= 1'b0;
				end
				EMIT_WRBYTE: begin
					op_q   <= OP_BUS_WRITE;
					addr_q <= cur_port;
					data_q <= rd_q;
					last_q <= 1'b0;
				end
				EMIT_GWAIT: begin
					op_q   <= OP_WAIT;
					wait_q <= grant_wait_us;
					last_q <= 1'b0;
				end
				EMIT_RWAIT: begin
					op_q   <= OP_WAIT;
					wait_q <= reply_wait_us;
					last_q <= 1'b0;
				end
				EMIT_DONE: begin
					op_q   <= OP_DONE;
					outc_q <= cmd.outcome;
				end
				EMIT_BYTE: begin
					op_q   <= OP_BUF_BYTE;
					byte_q <= rd_q;
				end
				default: ;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign op          = op_q;
	assign bus_address = addr_q;
	assign write_data  = data_q;
	assign wait_us     = wait_q;
	assign outcome     = outc_q;
	assign buffer_byte = byte_q;
	assign last        = last_q;

endmodule

FILE: rtl/core/ec_mailbox_transfer_core.sv
// Mailbox transfer core: host-side master for a 16-byte controller mailbox.
// Channels: input items (kind, index, value, write_mask, read_mask) on in_valid/in_stall;
// result items (op, bus_address, write_data, wait_us, outcome, buffer_byte, last) on
// out_valid/out_stall; configuration through the APB-style port (attempt limit at 0x0,
// grant wait at 0x4, reply wait at 0x8).
// One item is in work at a time; in_stall stays high until all its results are in
// the output register. A load item yields no result. Other items are accepted in
// idle and then give their results one by one as the output frees; each masked
// byte written after the grant is first fetched through the single read port of
// the buffer memory and then put out. The first result of an item is registered
// after the sequencer has left idle; last marks the final result of that item's run.
// While the receiver stalls, the output register holds its result and the sequencer
// waits; the next input item may be taken as soon as the final result is loaded.
// Reset returns to idle with no transfer open, the output empty and the registers at
// 100 attempts, 1 us grant wait and 500 us reply wait. Buffer bytes hold no value
// until loaded, read back from the mailbox or, for byte 15, set by a start item.
// Depends on ecmb_pkg, ecmb_regs, ecmb_ctrl and ecmb_dp.
module ec_mailbox_transfer_core
	import ecmb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [3:0]  index,
	input  logic [7:0]  value,
	input  logic [15:0] write_mask,
	input  logic [15:0] read_mask,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  op,
	output logic [4:0]  bus_address,
	output logic [7:0]  write_data,
	output logic [9:0]  wait_us,
	output logic [1:0]  outcome,
	output logic [7:0]  buffer_byte,
	output logic        last
);

	logic [7:0] attempt_limit;
	logic [9:0] grant_wait_us;
	logic [9:0] reply_wait_us;
	cmd_t       cmd;
	stat_t      stat;

	ecmb_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.attempt_limit (attempt_limit),
		.grant_wait_us (grant_wait_us),
		.reply_wait_us (reply_wait_us)
	);

	ecmb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.value    (value),
		.stat     (stat),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	ecmb_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.index         (index),
		.value         (value),
		.write_mask    (write_mask),
		.read_mask     (read_mask),
		.attempt_limit (attempt_limit),
		.grant_wait_us (grant_wait_us),
		.reply_wait_us (reply_wait_us),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.op            (op),
		.bus_address   (bus_address),
		.write_data    (write_data),
		.wait_us       (wait_us),
		.outcome       (outcome),
		.buffer_byte   (buffer_byte),
		.last          (last)
	);

endmodule

FILE: test/ec_mailbox_transfer_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for ec_mailbox_transfer_core: drives request items and register
// writes, predicts every bus op the core should emit, and checks the result stream in order.
// Depends on ecmb_pkg and the ec_mailbox_transfer_core RTL.
module ec_mailbox_transfer_core_test;
	import ecmb_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_ITEMS  = 10;

	typedef struct {
		logic [1:0]  kind;
		logic [3:0]  index;
		logic [7:0]  value;
		logic [15:0] wmask;
		logic [15:0] rmask;
	} request_t;

	typedef struct {
		logic [2:0] op;
		logic [4:0] addr;
		logic [7:0] wdata;
		logic [9:0] wait_len;
		logic [1:0] outc;
		logic [7:0] bbyte;
		logic       last_flag;
	} bus_op_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        psel        = 1'b0;
	logic        penable     = 1'b0;
	logic        pwrite      = 1'b0;
	logic [3:0]  paddr       = '0;
	logic [31:0] pwdata      = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [1:0]  kind        = '0;
	logic [3:0]  index       = '0;
	logic [7:0]  value       = '0;
	logic [15:0] write_mask  = '0;
	logic [15:0] read_mask   = '0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [2:0]  op;
	logic [4:0]  bus_address;
	logic [7:0]  write_data;
	logic [9:0]  wait_us;
	logic [1:0]  outcome;
	logic [7:0]  buffer_byte;
	logic        last;

	// Shadow copy of the core state and its registers
	logic [7:0]  shadow_buf [MAILBOX_BYTES];
	phase_t      shadow_phase   = PH_IDLE;
	logic [7:0]  shadow_tries   = '0;
	logic [15:0] shadow_wmask   = '0;
	logic [15:0] shadow_rmask   = '0;
	logic [3:0]  shadow_cursor  = '0;
	logic [7:0]  cfg_limit      = ATTEMPT_LIMIT_RST;
	logic [9:0]  cfg_grant_wait = GRANT_WAIT_RST;
	logic [9:0]  cfg_reply_wait = REPLY_WAIT_RST;
	bus_op_t     planned_ops [$];

	int   gap_pct     = 0;
	int   stall_pct   = 0;
	logic hold_stall  = 1'b0;
	int   fail_count  = 0;
	int   cycle_count = 0;

	ec_mailbox_transfer_core uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic void push_op(logic [2:0] op_code, logic [4:0] addr, logic [7:0] wdata,
			logic [9:0] wait_len, logic [1:0] outc, logic [7:0] bbyte);
		bus_op_t r;
		r.op        = op_code;
		r.addr      = addr;
		r.wdata     = wdata;
		r.wait_len  = wait_len;
		r.outc      = outc;
		r.bbyte     = bbyte;
		r.last_flag = 1'b0;
		planned_ops.push_back(r);
	endfunction

	function automatic void close_mailbox(logic [1:0] outc);
		push_op(OP_DONE, '0, '0, '0, outc, '0);
		shadow_phase = PH_IDLE;
	endfunction

	// Count one failed attempt; the 8-bit counter wraps, so a limit of zero means 256
	function automatic bit spend_attempt();
		shadow_tries = shadow_tries + 8'd1;
		return shadow_tries == cfg_limit;
	endfunction

	// Advance the shadow state by one accepted request and queue the bus ops it causes
	function automatic void plan_ops(request_t rq);
		int first;
		int i;
		first = planned_ops.size();
		case (rq.kind)
		KIND_LOAD: begin
			shadow_buf[rq.index] = rq.value;
		end
		KIND_READ: begin
			push_op(OP_BUF_BYTE, '0, '0, '0, OUTC_OK, shadow_buf[rq.index]);
		end
		KIND_START: begin
			if (shadow_phase == PH_IDLE) begin
				shadow_wmask  = rq.wmask | RET_BIT;
				shadow_rmask  = rq.rmask | RET_BIT;
				shadow_buf[15] = RET_INIT;
				shadow_tries  = '0;
				shadow_cursor = '0;
				push_op(OP_BUS_READ, ST_PORT, '0, '0, OUTC_OK, '0);
				shadow_phase = PH_ARB_STATUS;
			end
		end
		default: begin
			case (shadow_phase)
			PH_ARB_STATUS: begin
				if (rq.value[OBF_POS] || rq.value[SWMF_POS]) begin
					push_op(OP_BUS_READ, RET_PORT, '0, '0, OUTC_OK, '0);
					shadow_phase = PH_ARB_DRAIN;
				end else begin
					push_op(OP_BUS_WRITE, BASE_PORT, shadow_buf[0], '0, OUTC_OK, '0);
					push_op(OP_BUS_READ, ST_PORT, '0, '0, OUTC_OK, '0);
					shadow_phase = PH_ARB_CHECK;
				end
			end
			PH_ARB_DRAIN: begin
				if (spend_attempt()) begin
					close_mailbox(OUTC_NO_GRANT);
				end else begin
					push_op(OP_BUS_READ, ST_PORT, '0, '0, OUTC_OK, '0);
					shadow_phase = PH_ARB_STATUS;
				end
			end
			PH_ARB_CHECK: begin
				if (rq.value[MWMF_POS]) begin
					for (i = 1; i < MAILBOX_BYTES; i++)
						if (shadow_wmask[i])
							push_op(OP_BUS_WRITE, BASE_PORT + 5'(i), shadow_buf[i], '0,
								OUTC_OK, '0);
					push_op(OP_BUS_READ, ST_PORT, '0, '0, OUTC_OK, '0);
					shadow_tries = '0;
					shadow_phase = PH_REPLY;
				end else begin
					push_op(OP_WAIT, '0, '0, cfg_grant_wait, OUTC_OK, '0);
					if (spend_attempt()) begin
						close_mailbox(OUTC_NO_GRANT);
					end else begin
						push_op(OP_BUS_READ, ST_PORT, '0, '0, OUTC_OK, '0);
						shadow_phase = PH_ARB_STATUS;
					end
				end
			end
			PH_REPLY: begin
				if (rq.value[OBF_POS]) begin
					// Bit 15 is always set, so a first byte exists
					for (i = 0; i < MAILBOX_BYTES; i++)
						if (shadow_rmask[i]) break;
					shadow_cursor = 4'(i);
					push_op(OP_BUS_READ, BASE_PORT + 5'(i), '0, '0, OUTC_OK, '0);
					shadow_phase = PH_READING;
				end else begin
					push_op(OP_WAIT, '0, '0, cfg_reply_wait, OUTC_OK, '0);
					if (spend_attempt())
						close_mailbox(OUTC_NO_REPLY);
					else
						push_op(OP_BUS_READ, ST_PORT, '0, '0, OUTC_OK, '0);
				end
			end
			PH_READING: begin
				shadow_buf[shadow_cursor] = rq.value;
				for (i = shadow_cursor + 1; i < MAILBOX_BYTES; i++)
					if (shadow_rmask[i]) break;
				if (i < MAILBOX_BYTES) begin
					shadow_cursor = 4'(i);
					push_op(OP_BUS_READ, BASE_PORT + 5'(i), '0, '0, OUTC_OK, '0);
				end else begin
					close_mailbox(OUTC_OK);
				end
			end
			default: ;
			endcase
		end
		endcase
		if (planned_ops.size() > first)
			planned_ops[planned_ops.size() - 1].last_flag = 1'b1;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Check each result transfer against the oldest planned op, then pick the next stall
	always @(posedge clk) begin : check_results
		bus_op_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (planned_ops.size() == 0) begin
				$error("unplanned result: op %0d address 0x%0h", op, bus_address);
				fail_count++;
			end else begin
				want = planned_ops.pop_front();
				check_field("op", want.op, op);
				check_field("bus_address", want.addr, bus_address);
				check_field("write_data", want.wdata, write_data);
				check_field("wait_us", want.wait_len, wait_us);
				check_field("outcome", want.outc, outcome);
				check_field("buffer_byte", want.bbyte, buffer_byte);
				check_field("last", want.last_flag, last);
			end
		end
		out_stall <= hold_stall || ($urandom_range(99) < stall_pct);
	end

	function automatic request_t mk_req(logic [1:0] k, logic [3:0] idx, logic [7:0] val,
			logic [15:0] wm, logic [15:0] rm);
		request_t rq;
		rq.kind  = k;
		rq.index = idx;
		rq.value = val;
		rq.wmask = wm;
		rq.rmask = rm;
		return rq;
	endfunction

	function automatic logic [15:0] draw_mask();
		case ($urandom_range(9))
		0: return '0;
		1: return '1;
		default: return 16'($urandom);
		endcase
	endfunction

	// Bus answer with random content; pct sets how often it moves the mailbox forward
	function automatic logic [7:0] draw_answer(int pct);
		logic [7:0] v;
		v = 8'($urandom);
		case (shadow_phase)
		PH_ARB_STATUS: begin
			if ($urandom_range(99) < pct) begin
				v[OBF_POS]  = 1'b0;
				v[SWMF_POS] = 1'b0;
			end else if ($urandom_range(1) == 0) begin
				v[OBF_POS] = 1'b1;
			end else begin
				v[SWMF_POS] = 1'b1;
			end
		end
		PH_ARB_CHECK: v[MWMF_POS] = ($urandom_range(99) < pct);
		PH_REPLY: v[OBF_POS] = ($urandom_range(99) < pct);
		default: ;
		endcase
		return v;
	endfunction

	// Mostly well-formed mailbox traffic, with loads, read-backs and stray items mixed in
	function automatic request_t draw_request(output bit ignored);
		request_t rq;
		int roll;
		roll = $urandom_range(99);
		rq = mk_req(KIND_ANSWER, 4'($urandom), 8'($urandom), draw_mask(), draw_mask());
		ignored = 1'b0;
		if (shadow_phase == PH_IDLE) begin
			if (roll < 12) rq.kind = KIND_LOAD;
			else if (roll < 20) rq.kind = KIND_READ;
			else if (roll < 24) ignored = 1'b1;
			else rq.kind = KIND_START;
		end else begin
			if (roll < 8) begin
				rq.kind = KIND_LOAD;
			end else if (roll < 16) begin
				rq.kind = KIND_READ;
			end else if (roll < 20) begin
				rq.kind = KIND_START;
				ignored = 1'b1;
			end else begin
				rq.value = draw_answer(70);
			end
		end
		return rq;
	endfunction

	// Offer one request and hold it until the core takes the transfer
	task automatic send_request(request_t rq);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= rq.kind;
		index      <= rq.index;
		value      <= rq.value;
		write_mask <= rq.wmask;
		read_mask  <= rq.rmask;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		plan_ops(rq);
	endtask

	task automatic answer_bus(logic [7:0] v);
		send_request(mk_req(KIND_ANSWER, '0, v, '0, '0));
	endtask

	task automatic start_mailbox(logic [15:0] wm, logic [15:0] rm);
		send_request(mk_req(KIND_START, '0, '0, wm, rm));
	endtask

	// Answer with forward-moving status until the open mailbox run ends
	task automatic close_open_mailbox();
		while (shadow_phase != PH_IDLE) answer_bus(draw_answer(100));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (planned_ops.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
		REG_ATTEMPT_LIMIT: cfg_limit = data[7:0];
		REG_GRANT_WAIT: cfg_grant_wait = data[9:0];
		REG_REPLY_WAIT: cfg_reply_wait = data[9:0];
		default: ;
		endcase
		@(posedge clk);
	endtask

	// Reprogram only with no mailbox run open and the output side empty
	task automatic set_config(logic [7:0] limit, logic [9:0] gwait, logic [9:0] rwait);
		close_open_mailbox();
		wait_drained();
		write_reg(REG_ATTEMPT_LIMIT, 32'(limit));
		write_reg(REG_GRANT_WAIT, 32'(gwait));
		write_reg(REG_REPLY_WAIT, 32'(rwait));
	endtask

	// Fill every buffer entry, edges included, and read some back
	task automatic test_buffer_access();
		int i;
		for (i = 0; i < MAILBOX_BYTES; i++)
			send_request(mk_req(KIND_LOAD, 4'(i),
				(i == 0) ? 8'h00 : (i == 15) ? 8'hFF : 8'($urandom), '0, '0));
		send_request(mk_req(KIND_READ, 4'd0, '0, '0, '0));
		send_request(mk_req(KIND_READ, 4'd15, '0, '0, '0));
		send_request(mk_req(KIND_READ, 4'($urandom), '0, '0, '0));
	endtask

	// One full mailbox run through drains, a grant retry and a reply retry
	task automatic test_transfer_flow();
		answer_bus(8'hFF);
		start_mailbox(16'hFFFF, 16'h0001);
		answer_bus(8'h50);
		answer_bus(8'hFF);
		answer_bus(8'h10);
		answer_bus(8'h00);
		answer_bus(8'h00);
		answer_bus(8'hDF);
		answer_bus(8'hAF);
		start_mailbox(16'h1234, 16'hABCD);
		answer_bus(8'h20);
		answer_bus(8'hBF);
		send_request(mk_req(KIND_READ, 4'd3, '0, '0, '0));
		send_request(mk_req(KIND_LOAD, 4'd7, 8'h5A, '0, '0));
		answer_bus(8'h40);
		answer_bus(8'h00);
		answer_bus(8'hFF);
		send_request(mk_req(KIND_READ, 4'd0, '0, '0, '0));
		send_request(mk_req(KIND_READ, 4'd15, '0, '0, '0));
	endtask

	// Hit each failure outcome with tight attempt limits and extreme waits
	task automatic test_attempt_failures();
		set_config(8'd1, 10'd1023, 10'd0);
		start_mailbox(16'h0000, 16'h0000);
		answer_bus(8'h40);
		answer_bus(8'h12);
		start_mailbox(16'h0001, 16'h8000);
		answer_bus(8'h00);
		answer_bus(8'h00);
		start_mailbox(16'h8000, 16'h0000);
		answer_bus(8'h00);
		answer_bus(8'hFF);
		answer_bus(8'hBF);
		set_config(8'd2, 10'd0, 10'd1023);
		start_mailbox(16'h0002, 16'h4000);
		answer_bus(8'h00);
		answer_bus(8'h20);
		answer_bus(8'h00);
		answer_bus(8'h00);
	endtask

	// A zero limit allows 256 reply polls before giving up
	task automatic test_attempt_wrap();
		set_config(8'd0, 10'd5, 10'd7);
		start_mailbox(16'h0000, 16'h0000);
		answer_bus(8'h00);
		answer_bus(8'h20);
		while (shadow_phase != PH_IDLE) answer_bus(8'h00);
	endtask

	task automatic test_random_traffic();
		int p;
		int taken;
		bit ignored;
		request_t rq;
		for (p = 0; p < 4; p++) begin
			case (p)
			0: begin
				gap_pct   = 0;
				stall_pct = 0;
				set_config(8'd255, 10'd0, 10'd1023);
			end
			1: begin
				gap_pct   = 59;
				stall_pct = 0;
				set_config(8'd1, 10'd1023, 10'd0);
			end
			2: begin
				gap_pct   = 0;
				stall_pct = 59;
				set_config(8'($urandom_range(8, 2)), 10'($urandom), 10'($urandom));
			end
			default: begin
				gap_pct   = 25;
				stall_pct = 25;
				set_config(8'($urandom_range(6, 3)), 10'($urandom), 10'($urandom));
			end
			endcase
			taken = 0;
			while (taken < RANDOM_ITEMS) begin
				rq = draw_request(ignored);
				send_request(rq);
				if (!ignored) taken++;
			end
		end
	endtask

	// Hold the output off long enough for the core to stall its input
	task automatic test_backpressure();
		int i;
		gap_pct   = 0;
		stall_pct = 0;
		set_config(ATTEMPT_LIMIT_RST, GRANT_WAIT_RST, REPLY_WAIT_RST);
		fork
			begin
				hold_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_stall <= 1'b0;
			end
		join_none
		for (i = 0; i < 8; i++)
			send_request(mk_req(KIND_READ, 4'(i), '0, '0, '0));
		start_mailbox(16'hFFFF, 16'hFFFF);
		close_open_mailbox();
		wait_drained();
		start_mailbox(draw_mask(), draw_mask());
		close_open_mailbox();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_buffer_access();
		test_transfer_flow();
		test_attempt_failures();
		test_attempt_wrap();
		test_random_traffic();
		test_backpressure();
		close_open_mailbox();
		wait_drained();
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
